@@ hw/rtl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Conversion kinds carried in the cmd field
  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_HEXL = 3'd2,
    CMD_HEXU = 3'd3,
    CMD_PTR  = 3'd4
  } cmd_t;

  // Characters that come before the digits
  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_NEG  = 2'd1,
    PFX_HEX  = 2'd2
  } pfx_t;

  localparam int unsigned BIN_W         = 32;
  localparam int unsigned BCD_DIGITS    = 10;
  localparam int unsigned NIBBLES       = 16;
  localparam int unsigned DABBLE_STEPS  = 8;
  localparam int unsigned DABBLE_STAGES = BIN_W / DABBLE_STEPS;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'

  // Item moving through the decimal conversion stages
  typedef struct packed {
    pfx_t                        pfx;
    logic                        hex;
    logic                        upper;
    logic [63:0]                 val;
    logic [BIN_W-1:0]            bin;
    logic [BCD_DIGITS-1:0][3:0]  bcd;
  } work_t;

  // Item handed to the character emitter; digit 0 is least significant
  typedef struct packed {
    pfx_t                    pfx;
    logic                    upper;
    logic [NIBBLES-1:0][3:0] digs;
    logic [3:0]              top;
  } pack_t;

  // One digit to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

@@ hw/rtl/i2a_if.sv @@
// ----------------------------------------------------------------------------
// i2a channel interfaces
// Valid/ready channels for number beats in and character beats out.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ hw/rtl/i2a_decode.sv @@
// ----------------------------------------------------------------------------
// i2a_decode
// Input register: decodes the kind, takes the signed magnitude and seeds
// the decimal conversion. Unused kinds are taken and dropped.
// ----------------------------------------------------------------------------
module i2a_decode (
  input  logic          clk,
  input  logic          rst_n,
  i2a_in_if.sink        in_bus,
  output i2a_pkg::work_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);

  i2a_pkg::work_t nxt;
  logic           known;
  logic [31:0]    low;
  logic           valid_r;
  i2a_pkg::work_t data_r;

  assign in_bus.ready = !valid_r || out_ready;
  assign low          = in_bus.value[31:0];

  // Kind decode
  always_comb begin
    nxt       = '0;
    known     = 1'b1;
    nxt.val   = {32'd0, low};
    nxt.bin   = low;
    unique case (i2a_pkg::cmd_t'(in_bus.cmd))
      i2a_pkg::CMD_SDEC: begin
        // negation of the most negative value already reads as its magnitude
        if (low[31]) begin
          nxt.pfx = i2a_pkg::PFX_NEG;
          nxt.bin = (~low) + 32'd1;
        end
      end
      i2a_pkg::CMD_UDEC: begin
      end
      i2a_pkg::CMD_HEXL: nxt.hex = 1'b1;
      i2a_pkg::CMD_HEXU: begin
        nxt.hex   = 1'b1;
        nxt.upper = 1'b1;
      end
      i2a_pkg::CMD_PTR: begin
        nxt.hex = 1'b1;
        nxt.pfx = i2a_pkg::PFX_HEX;
        nxt.val = in_bus.value;
      end
      default: known = 1'b0;
    endcase
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid && known;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_bus.ready) begin
      data_r <= nxt;
    end
  end

  assign out_data  = data_r;
  assign out_valid = valid_r;

endmodule

@@ hw/rtl/i2a_dabble.sv @@
// ----------------------------------------------------------------------------
// i2a_dabble
// One pipeline stage of binary to BCD conversion: a fixed number of
// add-3-and-shift steps on the decimal digits, then a register.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic           clk,
  input  logic           rst_n,
  input  i2a_pkg::work_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output i2a_pkg::work_t out_data,
  output logic           out_valid,
  input  logic           out_ready
);

  i2a_pkg::work_t w;
  logic           valid_r;
  i2a_pkg::work_t data_r;

  assign in_ready = !valid_r || out_ready;

  // Shift-add-3 steps
  always_comb begin
    w = in_data;
    for (int s = 0; s < i2a_pkg::DABBLE_STEPS; s++) begin
      for (int k = 0; k < i2a_pkg::BCD_DIGITS; k++) begin
        if (w.bcd[k] >= 4'd5) begin
          w.bcd[k] = w.bcd[k] + 4'd3;
        end
      end
      {w.bcd, w.bin} = {w.bcd, w.bin} << 1;
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= w;
    end
  end

  assign out_data  = data_r;
  assign out_valid = valid_r;

endmodule

@@ hw/rtl/i2a_pack.sv @@
// ----------------------------------------------------------------------------
// i2a_pack
// Picks decimal or hex digits and finds the most significant nonzero digit.
// ----------------------------------------------------------------------------
module i2a_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  i2a_pkg::work_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output i2a_pkg::pack_t out_data,
  output logic           out_valid,
  input  logic           out_ready
);

  i2a_pkg::pack_t nxt;
  logic           valid_r;
  i2a_pkg::pack_t data_r;

  assign in_ready = !valid_r || out_ready;

  // Digit select and leading digit search; zero leaves top at digit 0
  always_comb begin
    nxt       = '0;
    nxt.pfx   = in_data.pfx;
    nxt.upper = in_data.upper;
    nxt.digs  = in_data.hex ? in_data.val : {24'd0, in_data.bcd};
    for (int k = 0; k < i2a_pkg::NIBBLES; k++) begin
      if (nxt.digs[k] != 4'd0) begin
        nxt.top = 4'(k);
      end
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= nxt;
    end
  end

  assign out_data  = data_r;
  assign out_valid = valid_r;

endmodule

@@ hw/rtl/i2a_emit.sv @@
// ----------------------------------------------------------------------------
// i2a_emit
// Character sequencer: prefix characters, then digits most significant first,
// one beat per cycle unless the receiver stalls, into an output register.
// ----------------------------------------------------------------------------
module i2a_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  i2a_pkg::pack_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  i2a_out_if.source      out_bus
);

  typedef enum logic [1:0] {
    PH_SIGN,
    PH_ZERO,
    PH_X,
    PH_DIG
  } phase_t;

  logic                    busy_r;
  phase_t                  phase_r;
  phase_t                  phase_nxt;
  logic [3:0]              pos_r;
  logic [15:0][3:0]        digs_r;
  logic                    upper_r;
  logic                    out_valid_r;
  logic [7:0]              out_ch_r;
  logic                    out_last_r;
  logic [7:0]              emit_ch;
  logic                    emit_last;
  logic                    adv;
  phase_t                  start_phase;

  assign in_ready = !busy_r;
  assign adv      = !out_valid_r || out_bus.ready;

  // First phase of a new item
  always_comb begin
    unique case (in_data.pfx)
      i2a_pkg::PFX_NEG: start_phase = PH_SIGN;
      i2a_pkg::PFX_HEX: start_phase = PH_ZERO;
      default:          start_phase = PH_DIG;
    endcase
  end

  // Current character
  always_comb begin
    emit_last = 1'b0;
    phase_nxt = PH_DIG;
    unique case (phase_r)
      PH_SIGN: emit_ch = i2a_pkg::CH_MINUS;
      PH_ZERO: begin
        emit_ch   = i2a_pkg::CH_ZERO;
        phase_nxt = PH_X;
      end
      PH_X:    emit_ch = i2a_pkg::CH_X;
      PH_DIG: begin
        emit_ch   = i2a_pkg::digit_char(digs_r[pos_r], upper_r);
        emit_last = (pos_r == 4'd0);
      end
      default: emit_ch = i2a_pkg::CH_ZERO;
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_DIG;
      out_valid_r <= 1'b0;
    end else begin
      if (!busy_r && in_valid) begin
        busy_r  <= 1'b1;
        phase_r <= start_phase;
        pos_r   <= in_data.top;
        digs_r  <= in_data.digs;
        upper_r <= in_data.upper;
      end
      if (adv) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          out_ch_r   <= emit_ch;
          out_last_r <= emit_last;
          phase_r    <= phase_nxt;
          if (phase_r == PH_DIG) begin
            if (emit_last) begin
              busy_r <= 1'b0;
            end else begin
              pos_r <= pos_r - 4'd1;
            end
          end
        end
      end
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.ch    = out_ch_r;
  assign out_bus.last  = out_last_r;

endmodule

@@ hw/rtl/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a number as ASCII decimal or hex characters, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  takes one beat per number: cmd (0 signed decimal, 1 unsigned
//           decimal, 2 hex lower, 3 hex upper, 4 pointer "0x" + 64-bit hex)
//           and value. Kinds 5 to 7 are taken and produce nothing.
//   out_bus gives one beat per character; last marks the final character.
//   Path: input register, four binary-to-BCD stages of 8 steps each, a digit
//   select stage, then the character sequencer and its output register.
//   The sequencer loads one item at a time and then emits its characters;
//   it takes no new item until its last character enters the output
//   register, and the stages in front hold up to six more numbers while
//   it works.
//   Reset (synchronous, rst_n low) empties every stage; no beat is lost or
//   repeated afterwards. When the receiver stalls, the output register holds
//   its beat and the pipeline backs up stage by stage until in_bus.ready
//   drops.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic      clk,
  input  logic      rst_n,
  i2a_in_if.sink    in_bus,
  i2a_out_if.source out_bus
);

  localparam int unsigned NST = i2a_pkg::DABBLE_STAGES;

  i2a_pkg::work_t dd_data  [0:NST];
  logic           dd_valid [0:NST];
  logic           dd_ready [0:NST];
  i2a_pkg::pack_t pk_data;
  logic           pk_valid;
  logic           pk_ready;

  // Kind decode and input register
  i2a_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_data  (dd_data[0]),
    .out_valid (dd_valid[0]),
    .out_ready (dd_ready[0])
  );

  // Binary to BCD stages
  for (genvar g = 0; g < NST; g++) begin : g_dabble
    i2a_dabble u_dabble (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_data   (dd_data[g]),
      .in_valid  (dd_valid[g]),
      .in_ready  (dd_ready[g]),
      .out_data  (dd_data[g+1]),
      .out_valid (dd_valid[g+1]),
      .out_ready (dd_ready[g+1])
    );
  end

  // Digit select and leading digit
  i2a_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (dd_data[NST]),
    .in_valid  (dd_valid[NST]),
    .in_ready  (dd_ready[NST]),
    .out_data  (pk_data),
    .out_valid (pk_valid),
    .out_ready (pk_ready)
  );

  // Character sequencer
  i2a_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (pk_data),
    .in_valid (pk_valid),
    .in_ready (pk_ready),
    .out_bus  (out_bus)
  );

  // A stalled digit-select stage keeps its item
  a_pack_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pk_valid && !pk_ready |=> pk_valid && $stable(pk_data))
    else $error("digit select stage lost its item under stall");

  // The final character of a number is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.last |->
      out_bus.ch != i2a_pkg::CH_MINUS && out_bus.ch != i2a_pkg::CH_X)
    else $error("number ended on a prefix character");

  // 'x' enters the output register as the leading '0' beat is taken
  a_x_after_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ch == i2a_pkg::CH_X &&
      $past(out_bus.valid && out_bus.ready) |->
      $past(out_bus.ch) == i2a_pkg::CH_ZERO && !$past(out_bus.last))
    else $error("pointer prefix out of order");

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("output beat present after reset");

endmodule

@@ tb/sv/i2a_char_compare.sv @@
// ----------------------------------------------------------------------------
// i2a_char_compare
// Watches both channels of the formatter, works out the characters of every
// accepted number and compares them, in order, with the character beats out.
// ----------------------------------------------------------------------------
module i2a_char_compare (
  input  logic        clk,
  input  logic        rst_n,
  i2a_in_if           in_bus,
  i2a_out_if          out_bus,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned chars_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  localparam string DIGITS_LO = "0123456789abcdef";
  localparam string DIGITS_UP = "0123456789ABCDEF";

  char_beat_t want_chars[$];
  char_beat_t got;

  // Append the characters one number should produce
  function automatic void predict_text(input logic [2:0] kind, input logic [63:0] value);
    logic [7:0]  text[$];
    logic [63:0] mag;
    logic [31:0] low;
    logic [63:0] radix;
    logic [3:0]  d;
    logic        upper;
    char_beat_t  beat;
    low   = value[31:0];
    upper = 1'b0;
    radix = 64'd16;
    case (kind)
      i2a_pkg::CMD_SDEC: begin
        radix = 64'd10;
        mag   = {32'd0, low};
        // negation in 32 bits leaves the most negative value at 2^31
        if (low[31]) begin
          text.push_back("-");
          mag = {32'd0, -low};
        end
      end
      i2a_pkg::CMD_UDEC: begin
        radix = 64'd10;
        mag   = {32'd0, low};
      end
      i2a_pkg::CMD_HEXL: mag = {32'd0, low};
      i2a_pkg::CMD_HEXU: begin
        mag   = {32'd0, low};
        upper = 1'b1;
      end
      i2a_pkg::CMD_PTR: begin
        text.push_back("0");
        text.push_back("x");
        mag = value;
      end
      default: return;  // spare kinds give nothing
    endcase
    // digits least significant first, inserted ahead of earlier ones
    begin
      int unsigned head;
      head = text.size();
      do begin
        d = 4'(mag % radix);
        text.insert(head, upper ? DIGITS_UP[d] : DIGITS_LO[d]);
        mag = mag / radix;
      end while (mag != 64'd0);
    end
    foreach (text[i]) begin
      beat.ch   = text[i];
      beat.last = (i == text.size() - 1);
      want_chars.push_back(beat);
    end
  endfunction

  initial begin
    errors        = 0;
    pending       = 0;
    chars_checked = 0;
  end

  // Predict on number beats, compare on character beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_text(in_bus.cmd, in_bus.value);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (want_chars.size() == 0) begin
          $error("unexpected character beat: ch 0x%02h last %0b", out_bus.ch, out_bus.last);
          errors++;
        end else begin
          got = want_chars.pop_front();
          chars_checked++;
          if (out_bus.ch !== got.ch) begin
            $error("ch: expected 0x%02h actual 0x%02h", got.ch, out_bus.ch);
            errors++;
          end
          if (out_bus.last !== got.last) begin
            $error("last: expected %0b actual %0b", got.last, out_bus.last);
            errors++;
          end
        end
      end
    end
    pending = want_chars.size();
  end

endmodule

@@ tb/sv/integer_to_ascii_formatter_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives numbers of every conversion kind into the formatter, first a set of
// edge values and then random ones, with random gaps and receiver stalls and
// one long receiver hold-off. A separate compare module checks every
// character beat.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
  localparam int unsigned RANDOM_NUMBERS  = 320;
  localparam int unsigned HOLD_AT_BEAT    = 60;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  logic        clk;
  logic        rst_n;
  int unsigned errors;
  int unsigned pending;
  int unsigned chars_checked;
  int unsigned kind_cnt[8];
  int          send_mode;

  i2a_in_if  in_bus ();
  i2a_out_if out_bus ();

  integer_to_ascii_formatter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  i2a_char_compare u_compare (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .out_bus      (out_bus),
    .errors       (errors),
    .pending      (pending),
    .chars_checked(chars_checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait drawn per beat: none, anything up to 18, or short
  function automatic int draw_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // One number beat: idle gap, then hold valid until taken
  task automatic send_number(input logic [2:0] kind, input logic [63:0] value);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.cmd   <= kind;
    in_bus.value <= value;
    do @(posedge clk); while (!in_bus.ready);
    kind_cnt[kind]++;
  endtask

  // Character receiver with random stalls and one long hold-off
  initial begin
    int unsigned beats;
    int          rmode;
    int          stall;
    beats = 0;
    rmode = 0;
    wait (rst_n);
    forever begin
      if (beats % 50 == 0) rmode = $urandom_range(0, 2);
      stall = (beats == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_wait(rmode);
      if (stall > 0) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      beats++;
    end
  end

  // Run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("integer_to_ascii_formatter_tb NOT OK");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    logic [2:0]  kind;
    logic [63:0] value;
    int unsigned sent;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.cmd    = i2a_pkg::CMD_SDEC;
    in_bus.value  = 64'd0;
    out_bus.ready = 1'b0;
    send_mode     = 1;
    foreach (kind_cnt[i]) kind_cnt[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Edge values: zero, extremes, most negative, ignored upper bits, spare kinds
    send_number(i2a_pkg::CMD_SDEC, 64'd0);
    send_number(i2a_pkg::CMD_SDEC, 64'd1);
    send_number(i2a_pkg::CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
    send_number(i2a_pkg::CMD_SDEC, 64'h0000_0000_8000_0000);
    send_number(i2a_pkg::CMD_SDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CMD_SDEC, 64'hDEAD_BEEF_FFFF_FFF6);
    send_number(i2a_pkg::CMD_UDEC, 64'd0);
    send_number(i2a_pkg::CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CMD_UDEC, 64'hFFFF_FFFF_0000_0009);
    send_number(i2a_pkg::CMD_UDEC, 64'd1_000_000_000);
    send_number(i2a_pkg::CMD_HEXL, 64'd0);
    send_number(i2a_pkg::CMD_HEXL, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEXL, 64'hABCD_EF01_2345_ABCD);
    send_number(i2a_pkg::CMD_HEXU, 64'd0);
    send_number(i2a_pkg::CMD_HEXU, 64'h0000_0000_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEXU, 64'h1234_5678_9ABC_DEF0);
    send_number(i2a_pkg::CMD_PTR, 64'd0);
    send_number(i2a_pkg::CMD_PTR, 64'd1);
    send_number(i2a_pkg::CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_PTR, 64'h8000_0000_0000_0000);
    send_number(CMD_SPARE_FIRST, {$urandom, $urandom});
    send_number(CMD_SPARE_FIRST + 3'd1, {$urandom, $urandom});
    send_number(CMD_SPARE_LAST, 64'd0);

    // Random numbers; spare kinds now and then do not count
    sent = 0;
    while (sent < RANDOM_NUMBERS) begin
      if (sent % 32 == 0) send_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 19) == 0) begin
        kind = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end else begin
        kind = 3'($urandom_range(i2a_pkg::CMD_SDEC, i2a_pkg::CMD_PTR));
        sent++;
      end
      value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       value = value >> $urandom_range(0, 63);  // spread of lengths
        1:       ;                                        // full width
        2:       value = 64'($urandom_range(0, 20));
        default: begin
          // sign boundary, all-ones and zero low words under random upper bits
          case ($urandom_range(0, 2))
            0:       value[31:0] = 32'h8000_0000;
            1:       value[31:0] = 32'hFFFF_FFFF;
            default: value[31:0] = 32'h0000_0000;
          endcase
        end
      endcase
      send_number(kind, value);
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;

    // Drain, then settle
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Numbers sent: signed %0d, unsigned %0d, hex lower %0d, hex upper %0d, pointer %0d,",
             kind_cnt[i2a_pkg::CMD_SDEC], kind_cnt[i2a_pkg::CMD_UDEC],
             kind_cnt[i2a_pkg::CMD_HEXL], kind_cnt[i2a_pkg::CMD_HEXU],
             kind_cnt[i2a_pkg::CMD_PTR]);
    $display("spare %0d; %0d character beats compared, one receiver hold-off of %0d cycles",
             kind_cnt[CMD_SPARE_FIRST] + kind_cnt[CMD_SPARE_FIRST + 3'd1] +
             kind_cnt[CMD_SPARE_LAST], chars_checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("integer_to_ascii_formatter_tb OK");
    end else begin
      $display("integer_to_ascii_formatter_tb NOT OK");
    end
    $finish;
  end

endmodule
